// File: src/pwlf_pkg.sv
// Shared constants, types and tables for the plane-wave lattice field block.
// No dependencies; imported by every other source file in the project.
package pwlf_pkg;

    localparam int COORD_BITS  = 12;
    localparam int PHASE_BITS  = 32;
    localparam int SAMPLE_BITS = 16;

    localparam int FIELD_BITS  = 16;
    localparam int REG_BITS    = 32;
    localparam int NUM_COMP    = 3;

    localparam int IN_BITS     = ((NUM_COMP * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * NUM_COMP * FIELD_BITS;

    // phase bits below PHASE_BITS are dropped
    localparam logic [31:0] PHASE_MASK =
        ~32'((64'd1 << (32 - PHASE_BITS)) - 64'd1);

    // register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_Z  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_Z = 3'd6;

    // CORDIC datapath
    localparam int CORDIC_ITERS = 28;
    localparam int CW           = 34;   // x/y width, 30 fraction bits
    localparam int ZW           = 32;   // residual angle width
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam int RSH          = 31 - SAMPLE_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LIM =
        SAMPLE_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] cs;
        logic signed [SAMPLE_BITS-1:0] sn;
    } t_phasor;

endpackage

// File: src/plane_wave_lattice_field.sv
// Plane-wave lattice field: site coordinates in, three complex field samples out.
// One beat per cycle sustained while the output skid's spare slot stays empty.
// Stages: coordinate multiply, phase sum, 30-stage CORDIC, complex multiply,
// round/saturate, output skid register. All stages before the skid register share
// one enable that drops only when its spare slot is full. Synchronous active-low
// reset clears all valid bits and the seven config registers to zero.
module plane_wave_lattice_field
    import pwlf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [REG_BITS-1:0]     i_cfg_data,
    // input stream
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [IN_BITS-1:0]      i_s_axis_tdata,  // site_x, site_y, site_z, zero pad
    // output stream
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [OUT_BITS-1:0]     o_m_axis_tdata   // x_re, x_im, y_re, y_im, z_re, z_im
);

    localparam int PW = FIELD_BITS + SAMPLE_BITS;   // product width
    localparam int SW = PW + 1;                     // sum width

    logic [REG_BITS-1:0] r_step [NUM_COMP];
    logic [REG_BITS-1:0] r_offset;
    logic [REG_BITS-1:0] r_field [NUM_COMP];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_COMP; m++) begin
                r_step[m]  <= '0;
                r_field[m] <= '0;
            end
            r_offset <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STEP_X:  r_step[0]  <= i_cfg_data;
                REG_STEP_Y:  r_step[1]  <= i_cfg_data;
                REG_STEP_Z:  r_step[2]  <= i_cfg_data;
                REG_OFFSET:  r_offset   <= i_cfg_data;
                REG_FIELD_X: r_field[0] <= i_cfg_data;
                REG_FIELD_Y: r_field[1] <= i_cfg_data;
                REG_FIELD_Z: r_field[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable, registered: low only while the skid spare holds a beat
    logic r_sv;
    logic en;
    assign en              = !r_sv;
    assign o_s_axis_tready = en;

    // stage 1: per-axis step times coordinate, modulo one turn
    logic                r_v1;
    logic [31:0]         r_prod [NUM_COMP];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < NUM_COMP; m++) begin
                r_prod[m] <= 32'($signed({1'b0, r_step[m]}) *
                    $signed(i_s_axis_tdata[m*COORD_BITS +: COORD_BITS]));
            end
        end
    end

    // stage 2: phase sum
    logic        r_v2;
    logic [31:0] r_phase;

    always_ff @(posedge i_clk) begin
        if (en)
            r_phase <= (r_offset + r_prod[0] + r_prod[1] + r_prod[2]) & PHASE_MASK;
    end

    logic    cor_v;
    t_phasor cor_ph;

    pwlf_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_v2),
        .i_phase  (r_phase),
        .o_valid  (cor_v),
        .o_phasor (cor_ph)
    );

    // complex multiply: per component a*c, b*s, a*s, b*c
    logic                 r_v3;
    logic signed [PW-1:0] r_pr [NUM_COMP][4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < NUM_COMP; m++) begin
                r_pr[m][0] <= $signed(r_field[m][31:16]) * cor_ph.cs;
                r_pr[m][1] <= $signed(r_field[m][15:0])  * cor_ph.sn;
                r_pr[m][2] <= $signed(r_field[m][31:16]) * cor_ph.sn;
                r_pr[m][3] <= $signed(r_field[m][15:0])  * cor_ph.cs;
            end
        end
    end

    function automatic logic [FIELD_BITS-1:0] to_q15(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        begin
            t = (v + $signed(SW'(64'd1 << (SAMPLE_BITS - 2)))) >>> (SAMPLE_BITS - 1);
            if (t > SW'(32767))
                to_q15 = 16'h7FFF;
            else if (t < -SW'(32768))
                to_q15 = 16'h8000;
            else
                to_q15 = t[FIELD_BITS-1:0];
        end
    endfunction

    // stage 4: sum, round, saturate
    logic                r_v4;
    logic [OUT_BITS-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < NUM_COMP; m++) begin
                r_res[(2*m)*FIELD_BITS +: FIELD_BITS] <=
                    to_q15(SW'(r_pr[m][0]) - SW'(r_pr[m][1]));
                r_res[(2*m+1)*FIELD_BITS +: FIELD_BITS] <=
                    to_q15(SW'(r_pr[m][2]) + SW'(r_pr[m][3]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= cor_v;
            r_v4 <= r_v3;
        end
    end

    // output skid: main register plus one spare beat
    logic                r_ov;
    logic [OUT_BITS-1:0] r_od;
    logic [OUT_BITS-1:0] r_sd;
    logic                out_fire;

    assign out_fire = r_ov && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (out_fire) begin
                r_od <= r_sd;
                r_sv <= 1'b0;
            end
        end else if (!r_ov || out_fire) begin
            r_ov <= r_v4;
            r_od <= r_res;
        end else if (r_v4) begin
            r_sv <= 1'b1;
            r_sd <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;

endmodule

// File: src/pwlf_cordic.sv
// Pipelined rotation CORDIC: phase in turns * 2^32 to cos/sin samples.
// Needs pwlf_pkg. 30 stages: input, one per iteration, output register.
module pwlf_cordic
    import pwlf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_phase,
    output logic        o_valid,
    output t_phasor     o_phasor
);

    logic signed [CW-1:0] r_x [CORDIC_ITERS+1];
    logic signed [CW-1:0] r_y [CORDIC_ITERS+1];
    logic signed [ZW-1:0] r_z [CORDIC_ITERS+1];
    logic [1:0]           r_q [CORDIC_ITERS+1];
    logic [CORDIC_ITERS+1:0] r_v;
    t_phasor              r_ph;

    logic [31:0]          n_a;
    logic signed [ZW-1:0] n_z0;

    // shift by 1/8 turn so the top two bits pick the quadrant
    assign n_a  = i_phase + 32'h2000_0000;
    assign n_z0 = $signed({2'b00, n_a[29:0]}) - 32'sh2000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_q[0] <= n_a[31:30];
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        logic signed [CW-1:0] n_dx;
        logic signed [CW-1:0] n_dy;
        logic signed [ZW-1:0] n_at;
        assign n_dx = r_y[i] >>> i;
        assign n_dy = r_x[i] >>> i;
        assign n_at = $signed(ATAN_TURNS[i]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - n_dx;
                    r_y[i+1] <= r_y[i] + n_dy;
                    r_z[i+1] <= r_z[i] - n_at;
                end else begin
                    r_x[i+1] <= r_x[i] + n_dx;
                    r_y[i+1] <= r_y[i] - n_dy;
                    r_z[i+1] <= r_z[i] + n_at;
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    // round half up to SAMPLE_BITS, clamp to symmetric range
    function automatic logic signed [SAMPLE_BITS-1:0] round_lim(
        input logic signed [CW-1:0] v
    );
        logic signed [CW-1:0] t;
        begin
            t = (v + $signed(CW'(64'd1 << (RSH - 1)))) >>> RSH;
            if (t > CW'(SAMPLE_LIM))
                round_lim = SAMPLE_LIM;
            else if (t < -CW'(SAMPLE_LIM))
                round_lim = -SAMPLE_LIM;
            else
                round_lim = t[SAMPLE_BITS-1:0];
        end
    endfunction

    logic signed [SAMPLE_BITS-1:0] n_c;
    logic signed [SAMPLE_BITS-1:0] n_s;
    t_phasor                       n_ph;

    assign n_c = round_lim(r_x[CORDIC_ITERS]);
    assign n_s = round_lim(r_y[CORDIC_ITERS]);

    always_comb begin
        unique case (r_q[CORDIC_ITERS])
            QUAD_0: begin n_ph.cs = n_c;  n_ph.sn = n_s;  end
            QUAD_1: begin n_ph.cs = -n_s; n_ph.sn = n_c;  end
            QUAD_2: begin n_ph.cs = -n_c; n_ph.sn = -n_s; end
            QUAD_3: begin n_ph.cs = n_s;  n_ph.sn = -n_c; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_ph <= n_ph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v <= '0;
        else if (i_en)
            r_v <= {r_v[CORDIC_ITERS:0], i_valid};
    end

    assign o_valid  = r_v[CORDIC_ITERS+1];
    assign o_phasor = r_ph;

endmodule

// File: tb/pwlf_field_checker.sv
// Checker for plane_wave_lattice_field: tracks register writes, predicts the three
// complex field samples of every accepted site beat and compares output beats in order.
// Depends on pwlf_pkg for widths, register indexes and the arctangent table.
module pwlf_field_checker
    import pwlf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [REG_BITS-1:0]     i_cfg_data,
    input  logic                    i_s_axis_tvalid,
    input  logic                    i_s_axis_tready,
    input  logic [IN_BITS-1:0]      i_s_axis_tdata,
    input  logic                    i_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    input  logic [OUT_BITS-1:0]     i_m_axis_tdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int NUM_REGS = REG_FIELD_Z + 1;

    logic [REG_BITS-1:0] site_regs [NUM_REGS];
    logic [OUT_BITS-1:0] pending_fields [$];
    string               field_names [2*NUM_COMP] =
        '{"out_x_re", "out_x_im", "out_y_re", "out_y_im", "out_z_re", "out_z_im"};
    int                  fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [FIELD_BITS-1:0] to_q15(input longint v);
        return FIELD_BITS'(clip(round_half_up(v, SAMPLE_BITS - 1), -32768, 32767));
    endfunction

    // cos/sin of a phase in turns * 2^32, octant-folded CORDIC then quadrant swap
    function automatic void unit_phasor(input logic [31:0] phase,
                                        output longint cs, output longint sn);
        logic [31:0] angle;
        longint      x, y, z, dx, dy, c, s, lim;
        int          i;
        angle = phase + 32'h2000_0000;
        z     = longint'(angle[29:0]) - longint'(32'h2000_0000);
        x     = longint'(CORDIC_X0);
        y     = 0;
        lim   = longint'(SAMPLE_LIM);
        for (i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURNS[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end
        c = clip(round_half_up(x, RSH), -lim, lim);
        s = clip(round_half_up(y, RSH), -lim, lim);
        case (angle[31:30])
            QUAD_0: begin
                cs = c;
                sn = s;
            end
            QUAD_1: begin
                cs = -s;
                sn = c;
            end
            QUAD_2: begin
                cs = -c;
                sn = -s;
            end
            default: begin
                cs = s;
                sn = -c;
            end
        endcase
    endfunction

    function automatic logic [OUT_BITS-1:0] predict_site_field(input logic [IN_BITS-1:0] site);
        logic [31:0]                  phase, coord;
        logic signed [FIELD_BITS-1:0] fa, fb;
        longint                       cs, sn;
        logic [OUT_BITS-1:0]          res;
        int                           m;
        phase = site_regs[REG_OFFSET];
        for (m = 0; m < NUM_COMP; m++) begin
            coord = {{(32-COORD_BITS){site[m*COORD_BITS + COORD_BITS - 1]}},
                     site[m*COORD_BITS +: COORD_BITS]};
            phase = phase + site_regs[REG_STEP_X + m] * coord;
        end
        phase = phase & PHASE_MASK;
        unit_phasor(phase, cs, sn);
        for (m = 0; m < NUM_COMP; m++) begin
            fa = site_regs[REG_FIELD_X + m][31:16];
            fb = site_regs[REG_FIELD_X + m][15:0];
            res[2*m*FIELD_BITS +: FIELD_BITS]     = to_q15(longint'(fa) * cs - longint'(fb) * sn);
            res[(2*m+1)*FIELD_BITS +: FIELD_BITS] = to_q15(longint'(fa) * sn + longint'(fb) * cs);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_BITS-1:0]          want;
        logic signed [FIELD_BITS-1:0] w, g;
        int                           f;
        if (!i_rst_n) begin
            foreach (site_regs[r]) site_regs[r] = '0;
            pending_fields.delete();
        end else begin
            // indexes past the last register are dropped by the block
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= REG_FIELD_Z)
                site_regs[i_cfg_index] = i_cfg_data;
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_fields.size() == 0) begin
                    $error("field beat %h with no site outstanding", i_m_axis_tdata);
                    fail_total++;
                end else begin
                    want = pending_fields.pop_front();
                    for (f = 0; f < 2*NUM_COMP; f++) begin
                        w = want[f*FIELD_BITS +: FIELD_BITS];
                        g = i_m_axis_tdata[f*FIELD_BITS +: FIELD_BITS];
                        if (w !== g) begin
                            $error("%s: expected %0d, got %0d", field_names[f], w, g);
                            fail_total++;
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                pending_fields.push_back(predict_site_field(i_s_axis_tdata));
        end
        o_pending    <= pending_fields.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: tb/testbench.sv
// Top of the plane_wave_lattice_field bench: clock, reset, register settings,
// site beats and output back-pressure; verdict taken from pwlf_field_checker.
// Depends on pwlf_pkg, plane_wave_lattice_field and pwlf_field_checker.
module testbench;
    import pwlf_pkg::*;

    localparam int NUM_REGS    = REG_FIELD_Z + 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;   // not decoded by the block
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 40;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_SITES = 90;

    // quarter turn on x, eighth turn on y, -1 step on z
    localparam int DIRECTED [20][3] = '{
        '{0, 0, 0},         '{1, 0, 0},     '{2, 0, 0},     '{3, 0, 0},
        '{0, 1, 0},         '{0, 3, 0},     '{0, 5, 0},     '{0, 7, 0},
        '{-2048, -2048, -2048}, '{2047, 2047, 2047}, '{-1, -1, -1},
        '{0, 0, 1},         '{0, 0, -1},    '{-2048, 0, 0}, '{2047, 0, 0},
        '{0, -2048, 0},     '{0, 2047, 0},  '{0, 0, 2047},  '{1365, -1366, 1365},
        '{-1366, 1365, -1366}
    };

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]     cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_BITS-1:0]      s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_BITS-1:0]     m_tdata;

    int  fail_count;
    int  pending;
    bit  gaps_on  = 1'b1;
    bit  hold_req = 1'b0;
    int  sites_sent  = 0;
    int  reg_writes  = 0;
    int  settings_run = 0;
    logic [REG_BITS-1:0] setting [NUM_REGS];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    plane_wave_lattice_field i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    pwlf_field_checker u_field_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
    endtask

    // caller guarantees the block is drained
    task automatic apply_setting(input bit poke_spare);
        int r;
        if (poke_spare)
            write_reg(REG_SPARE, $urandom);
        for (r = REG_STEP_X; r <= REG_FIELD_Z; r++)
            write_reg(CFG_IDX_BITS'(r), setting[r]);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_site(input logic [COORD_BITS-1:0] sx, sy, sz);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'({sz, sy, sx});
        do @(posedge clk); while (!s_tready);
        sites_sent++;
    endtask

    task automatic send_random_site();
        logic [COORD_BITS-1:0] c [NUM_COMP];
        foreach (c[a]) begin
            case ($urandom_range(0, 7))
                0, 1:    c[a] = COORD_BITS'($urandom_range(0, 15) - 8);
                2:       c[a] = $urandom_range(0, 1) ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                                     : {1'b0, {(COORD_BITS-1){1'b1}}};
                default: c[a] = COORD_BITS'($urandom);
            endcase
        end
        send_site(c[0], c[1], c[2]);
    endtask

    task automatic finish_phase();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_half();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // output side: random stalls, one long hold-off on request
    initial begin
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        int ph, r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: zero field everywhere
        send_site('0, '0, '0);
        send_site('1, '1, '1);
        finish_phase();

        setting[REG_STEP_X]  = 32'h4000_0000;
        setting[REG_STEP_Y]  = 32'h2000_0000;
        setting[REG_STEP_Z]  = 32'hFFFF_FFFF;
        setting[REG_OFFSET]  = 32'h0000_0000;
        setting[REG_FIELD_X] = 32'h7FFF_7FFF;
        setting[REG_FIELD_Y] = 32'h8000_8000;
        setting[REG_FIELD_Z] = 32'h4000_C000;
        apply_setting(1'b1);
        settings_run++;
        foreach (DIRECTED[i])
            send_site(COORD_BITS'(DIRECTED[i][0]), COORD_BITS'(DIRECTED[i][1]),
                      COORD_BITS'(DIRECTED[i][2]));
        finish_phase();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            for (r = REG_STEP_X; r <= REG_STEP_Z; r++) begin
                case (ph)
                    0:       setting[r] = '0;
                    1:       setting[r] = '1;
                    3:       setting[r] = $urandom_range(0, 32'h0010_0000);
                    default: setting[r] = $urandom;
                endcase
            end
            setting[REG_OFFSET] = (ph == 1) ? '1 : REG_BITS'($urandom);
            for (r = REG_FIELD_X; r <= REG_FIELD_Z; r++)
                setting[r] = (ph == 1) ? '1 : {rand_half(), rand_half()};
            apply_setting(ph % 2 == 0);
            settings_run++;
            if (ph == 2)
                hold_req = 1'b1;
            if (ph == NUM_PHASES - 1)
                gaps_on = 1'b0;
            repeat (PHASE_SITES) send_random_site();
            finish_phase();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Run covered %0d site beats over %0d register settings (%0d register writes),",
                 sites_sent, settings_run, reg_writes);
        $display("with random gaps and stalls on both streams and one long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
src/pwlf_pkg.sv
src/pwlf_cordic.sv
src/plane_wave_lattice_field.sv
tb/pwlf_field_checker.sv
tb/testbench.sv
